/* rtl/core/adcd_pkg.sv */
// Shared types and constants for the ADC sample channel demultiplexer.
`timescale 1ns / 1ps

package adcd_pkg;

  localparam int NUM_CHANNELS = 7;
  localparam int MAX_SAMPLES  = 1024;

  localparam int CH_W     = $clog2(NUM_CHANNELS);
  localparam int CNT_W    = $clog2(MAX_SAMPLES) + 1;
  localparam int SLOT_W   = $clog2(MAX_SAMPLES);
  localparam int TAG_W    = 4;
  localparam int SAMPLE_W = 12;
  localparam int WORD_W   = 20;
  localparam int TAG_LSB  = 16;
  localparam int REG_W    = 11;
  localparam int REG_IDX_W = 3;

  localparam logic [CNT_W-1:0] MAX_LIMIT = CNT_W'(MAX_SAMPLES);

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_WORD  = 1'b1
  } action_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_CAP0   = 3'd1,
    REG_CAP1   = 3'd2,
    REG_CAP2   = 3'd3,
    REG_CAP3   = 3'd4,
    REG_CAP4   = 3'd5,
    REG_CAP5   = 3'd6,
    REG_CAP6   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic                action;
    logic [WORD_W-1:0]   fifo_word;
    logic [CNT_W-1:0]    quota;
  } word_req_t;

  typedef struct packed {
    logic                    store_valid;
    logic [TAG_W-1:0]        channel;
    logic [SLOT_W-1:0]       slot_index;
    logic [SAMPLE_W-1:0]     sample_value;
    logic [NUM_CHANNELS-1:0] pending_mask;
    logic                    run_done;
    logic                    bad_tag;
  } result_t;

  // Limits above the buffer depth act as the buffer depth.
  function automatic logic [CNT_W-1:0] clamp_limit(input logic [REG_W-1:0] v);
    logic [CNT_W-1:0] w;
    w = CNT_W'(v);
    return (w > MAX_LIMIT) ? MAX_LIMIT : w;
  endfunction

endpackage

/* rtl/core/adcd_word_if.sv */
// Valid/ready channel carrying FIFO word requests.
`timescale 1ns / 1ps

interface adcd_word_if
  import adcd_pkg::*;
;
  logic      valid;
  logic      ready;
  word_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/adcd_result_if.sv */
// Valid/ready channel carrying demux results.
`timescale 1ns / 1ps

interface adcd_result_if
  import adcd_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/adc_sample_channel_demux.sv */
// Top level: routes channel-tagged ADC FIFO words to per-channel buffer slots.
//
//   port      dir  handshake     content
//   words     in   valid/ready   action, fifo_word, quota
//   results   out  valid/ready   store_valid, channel, slot_index, sample_value,
//                                pending_mask, run_done, bad_tag
//   wr_*      in   wr_en only    register index, 11-bit data
//
// One request per cycle unless the skid is full; each result is registered.
// Counts and pending mask update in the accept cycle, so back-to-back words
// on one channel see each other. A two-entry output stage (result register
// plus skid) keeps words.ready high while one result waits.
// rst is synchronous: counts, pending, quota and registers clear to zero.
`timescale 1ns / 1ps

module adc_sample_channel_demux
  import adcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  adcd_word_if.sink            words,
  adcd_result_if.source        results
);

  logic [NUM_CHANNELS-1:0] enable_mask;
  logic [REG_W-1:0]        caps [NUM_CHANNELS];
  logic [CNT_W-1:0]        counts [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pending;
  logic [REG_W-1:0]        run_quota;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic                    accept;
  logic [TAG_W-1:0]        tag;
  logic [CH_W-1:0]         ch;
  logic                    tag_ok;
  logic [CNT_W-1:0]        cnt;
  logic [REG_W-1:0]        cap_sel;
  logic                    room;
  logic [NUM_CHANNELS-1:0] pending_next;
  result_t                 res;

  assign accept        = words.valid && words.ready;
  assign words.ready   = !skid_valid;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  assign tag    = words.data.fifo_word[TAG_LSB +: TAG_W];
  assign ch     = tag[CH_W-1:0];
  assign tag_ok = (tag < TAG_W'(NUM_CHANNELS)) && enable_mask[ch];

  always_comb begin
    cnt     = '0;
    cap_sel = '0;
    if (tag_ok) begin
      cnt     = counts[ch];
      cap_sel = caps[ch];
    end
  end

  assign room = (cnt < clamp_limit(cap_sel)) && (cnt < clamp_limit(run_quota));

  always_comb begin
    pending_next = pending;
    res          = '0;
    if (words.data.action == ACT_START) begin
      pending_next = enable_mask;
    end else begin
      res.channel      = tag;
      res.sample_value = words.data.fifo_word[SAMPLE_W-1:0];
      if (!tag_ok) begin
        res.bad_tag = 1'b1;
      end else if (room) begin
        res.store_valid = 1'b1;
        res.slot_index  = cnt[SLOT_W-1:0];
      end else begin
        pending_next[ch] = 1'b0;
      end
    end
    res.pending_mask = pending_next;
    res.run_done     = (pending_next == '0);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        caps[i] <= '0;
      end
    end else if (wr_en) begin
      if (wr_index == REG_ENABLE) begin
        enable_mask <= wr_data[NUM_CHANNELS-1:0];
      end else if (wr_index <= REG_IDX_W'(NUM_CHANNELS)) begin
        caps[CH_W'(wr_index - REG_CAP0)] <= wr_data;
      end
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      run_quota <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        counts[i] <= '0;
      end
    end else if (accept) begin
      pending <= pending_next;
      if (words.data.action == ACT_START) begin
        run_quota <= words.data.quota;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          counts[i] <= '0;
        end
      end else if (tag_ok && room) begin
        counts[ch] <= cnt + CNT_W'(1);
      end
    end
  end

  // result register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || results.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || results.ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= res;
      end
    end else if (accept) begin
      skid_data <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_store_good_tag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.store_valid) |->
      (!out_data.bad_tag && out_data.channel < TAG_W'(NUM_CHANNELS)))
    else $error("stored sample carries a bad channel tag");

  a_done_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.run_done == (out_data.pending_mask == '0)))
    else $error("run_done disagrees with pending mask");

endmodule
